[design/tsbe_pkg.sv]
// Package for the two-bit state bitmap engine: sizes, command and status
// codes, sequencer states and the scan result struct.
// No dependencies; compile first.
package tsbe_pkg;

  localparam int BITMAP_BYTES = 1024;
  localparam int ADDR_W       = $clog2(BITMAP_BYTES);
  localparam int BYTES_W      = 11;
  localparam int CMD_W        = 2;
  localparam int INDEX_W      = 12;
  localparam int STATE_W      = 2;
  localparam int STATUS_W     = 2;
  localparam int VALUE_W      = 13;
  localparam int LANES        = 4;
  localparam int BYTE_W       = LANES * STATE_W;
  localparam int CNT_W        = $clog2(LANES + 1);
  localparam int POS_W        = $clog2(LANES);

  localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIND  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COUNT = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_WR,
    ST_SCAN,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] count;
  } scan_res_t;

endpackage

[design/tsbe_if.sv]
// Valid/ready channel interfaces for the command and result beats.
// Depends on tsbe_pkg.
interface tsbe_in_if;
  import tsbe_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [INDEX_W-1:0] entry_index;
  logic [STATE_W-1:0] state_value;
  modport source (output valid, output command, output entry_index,
                  output state_value, input ready);
  modport sink   (input valid, input command, input entry_index,
                  input state_value, output ready);
endinterface

interface tsbe_out_if;
  import tsbe_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  result_value;
  modport source (output valid, output status, output result_value, input ready);
  modport sink   (input valid, input status, input result_value, output ready);
endinterface

[design/tsbe_ram.sv]
// Bitmap byte store: one write port, one read port with registered data.
// Depends on tsbe_pkg.
module tsbe_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tsbe_pkg::ADDR_W-1:0] waddr,
  input  logic [tsbe_pkg::BYTE_W-1:0] wdata,
  input  logic [tsbe_pkg::ADDR_W-1:0] raddr,
  output logic [tsbe_pkg::BYTE_W-1:0] rdata
);
  import tsbe_pkg::*;

  logic [BYTE_W-1:0] mem [BITMAP_BYTES];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/tsbe_scan.sv]
// Shared byte scan unit: compares the four entries of one byte to a state,
// gives hit, first matching lane and match count. Depends on tsbe_pkg.
module tsbe_scan (
  input  logic [tsbe_pkg::BYTE_W-1:0]  byte_data,
  input  logic [tsbe_pkg::STATE_W-1:0] match_value,
  input  logic [tsbe_pkg::LANES-1:0]   lane_en,
  output tsbe_pkg::scan_res_t          res
);
  import tsbe_pkg::*;

  always_comb begin
    logic [LANES-1:0] m;
    res = '0;
    for (int k = 0; k < LANES; k++) begin
      m[k] = lane_en[k] && (byte_data[k*STATE_W +: STATE_W] == match_value);
    end
    // priority from the highest lane down so the lowest match wins
    for (int k = LANES - 1; k >= 0; k--) begin
      if (m[k]) begin
        res.pos = POS_W'(k);
      end
    end
    for (int k = 0; k < LANES; k++) begin
      res.count = res.count + CNT_W'(m[k]);
    end
    res.hit = |m;
  end

endmodule

[design/two_bit_state_bitmap_engine_unit.sv]
// Top level of the two-bit state bitmap engine: sequencer, byte store and
// shared scan unit. Depends on tsbe_pkg, tsbe_if, tsbe_ram, tsbe_scan.
//
//   channel   direction  handshake        payload
//   in_ch     sink       valid / ready    command, entry_index, state_value
//   out_ch    source     valid / ready    status, result_value
//   cfg       write      cfg_we           cfg_wdata (bytes_in_use)
//
// A set reads its byte at accept, writes the merged byte in ST_SET_WR and
// then enters ST_DONE; find and count read the bytes through the single
// store read port, one byte per cycle through the scan unit. A command
// refused up front (set or goal outside the region, count of an empty
// region, unused code) goes straight from accept to ST_DONE. After reset a
// clearing pass writes all 1024 bytes, one a cycle, with no command accepted.
// A result waits in the output register while the next command runs; a
// finished command holds in its done state until that register is free.
module two_bit_state_bitmap_engine_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  tsbe_in_if.sink                      in_ch,
  tsbe_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [tsbe_pkg::BYTES_W-1:0] cfg_wdata
);
  import tsbe_pkg::*;

  seq_state_t           state_r, state_nxt;
  logic [ADDR_W-1:0]    clr_addr_r, clr_addr_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [INDEX_W-1:0]   idx_r, idx_nxt;
  logic [STATE_W-1:0]   val_r, val_nxt;
  logic [ADDR_W-1:0]    scan_addr_r, scan_addr_nxt;
  logic                 iss_r, iss_nxt;
  logic                 rd_v_r, rd_v_nxt;
  logic [ADDR_W-1:0]    rd_byte_r, rd_byte_nxt;
  logic                 first_r, first_nxt;
  logic [VALUE_W-1:0]   acc_r, acc_nxt;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [VALUE_W-1:0]   res_value_r, res_value_nxt;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [VALUE_W-1:0]   out_value_r;
  logic [BYTES_W-1:0]   bytes_r;

  logic [BYTES_W-1:0]   lim;
  logic [ADDR_W-1:0]    lim_last;
  logic [VALUE_W-1:0]   limit;
  logic                 out_free;
  logic                 load_out;
  logic                 in_ready;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [BYTE_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [BYTE_W-1:0]    ram_rdata;
  logic [BYTE_W-1:0]    wbyte;
  logic [LANES-1:0]     lane_en;
  logic [VALUE_W-1:0]   acc_sum;
  scan_res_t            sres;

  // Region in use, clamped to the store size; limit is in entries.
  assign lim      = (bytes_r > BYTES_W'(BITMAP_BYTES)) ? BYTES_W'(BITMAP_BYTES) : bytes_r;
  assign lim_last = ADDR_W'(lim - BYTES_W'(1));
  assign limit    = {lim, 2'b00};

  assign out_free = !out_valid_r || out_ch.ready;

  tsbe_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Only the goal byte of a find masks off the lanes below the goal.
  assign lane_en = (first_r && (cmd_r == CMD_FIND)) ? (4'b1111 << idx_r[1:0]) : 4'b1111;

  tsbe_scan u_scan (
    .byte_data   (ram_rdata),
    .match_value (val_r),
    .lane_en     (lane_en),
    .res         (sres)
  );

  assign acc_sum = acc_r + VALUE_W'(sres.count);

  // Merge the new state into the byte read at accept time.
  always_comb begin
    wbyte = ram_rdata;
    wbyte[{idx_r[1:0], 1'b0} +: STATE_W] = val_r;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    scan_addr_nxt  = scan_addr_r;
    iss_nxt        = iss_r;
    rd_v_nxt       = rd_v_r;
    rd_byte_nxt    = rd_byte_r;
    first_nxt      = first_r;
    acc_nxt        = acc_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[INDEX_W-1:2];
    ram_wdata      = wbyte;
    ram_raddr      = in_ch.entry_index[INDEX_W-1:2];
    load_out       = 1'b0;
    in_ready       = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        // sweep the store to the free state
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(BITMAP_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          cmd_nxt        = in_ch.command;
          idx_nxt        = in_ch.entry_index;
          val_nxt        = in_ch.state_value;
          res_status_nxt = STAT_OK;
          res_value_nxt  = '0;
          acc_nxt        = '0;
          first_nxt      = 1'b1;
          rd_v_nxt       = 1'b0;
          iss_nxt        = 1'b1;
          state_nxt      = ST_DONE;
          case (in_ch.command)
            CMD_SET: begin
              if (VALUE_W'(in_ch.entry_index) < limit) begin
                state_nxt = ST_SET_WR;
              end else begin
                res_status_nxt = STAT_RANGE;
              end
            end
            CMD_FIND: begin
              if (VALUE_W'(in_ch.entry_index) < limit) begin
                scan_addr_nxt = in_ch.entry_index[INDEX_W-1:2];
                state_nxt     = ST_SCAN;
              end else begin
                res_status_nxt = STAT_NOT_FOUND;
              end
            end
            CMD_COUNT: begin
              if (lim != '0) begin
                scan_addr_nxt = '0;
                state_nxt     = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SET_WR: begin
        ram_we    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        // issue side: one byte read per cycle up to the last byte in use
        ram_raddr   = scan_addr_r;
        rd_v_nxt    = iss_r;
        rd_byte_nxt = scan_addr_r;
        if (iss_r) begin
          if (scan_addr_r == lim_last) begin
            iss_nxt = 1'b0;
          end else begin
            scan_addr_nxt = scan_addr_r + ADDR_W'(1);
          end
        end
        // return side: evaluate the byte read last cycle
        if (rd_v_r) begin
          first_nxt = 1'b0;
          if (cmd_r == CMD_FIND) begin
            if (sres.hit) begin
              res_status_nxt = STAT_OK;
              res_value_nxt  = VALUE_W'({rd_byte_r, sres.pos});
              state_nxt      = ST_DONE;
            end else if (rd_byte_r == lim_last) begin
              res_status_nxt = STAT_NOT_FOUND;
              state_nxt      = ST_DONE;
            end
          end else begin
            acc_nxt = acc_sum;
            if (rd_byte_r == lim_last) begin
              res_value_nxt = acc_sum;
              state_nxt     = ST_DONE;
            end
          end
        end
      end
      ST_DONE: begin
        // hold until the output register can take the beat
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      iss_r      <= 1'b0;
      rd_v_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      iss_r      <= iss_nxt;
      rd_v_r     <= rd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    scan_addr_r  <= scan_addr_nxt;
    rd_byte_r    <= rd_byte_nxt;
    first_r      <= first_nxt;
    acc_r        <= acc_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
  end

  // Output register: load a finished result, drop valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= BYTES_W'(1024);
    end else if (cfg_we) begin
      bytes_r <= cfg_wdata;
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.result_value = out_value_r;

`ifndef NO_ASSERTIONS
  // A store write outside the clearing pass follows an accepted set beat.
  a_write_after_set: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (state_r != ST_CLEAR)) |->
      ($past(in_ch.valid && in_ch.ready) && ($past(in_ch.command) == CMD_SET)))
    else $error("store write without a preceding set");

  // A found index lies between the goal and the end of the region.
  a_find_in_region: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && (cmd_r == CMD_FIND) && (res_status_r == STAT_OK)) |->
      ((res_value_r >= VALUE_W'(idx_r)) && (res_value_r < limit)))
    else $error("find result outside goal and region");

  // A count never exceeds the number of entries in use.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && (cmd_r == CMD_COUNT)) |-> (res_value_r <= limit))
    else $error("count above entries in use");

  // The clearing pass ends after its last byte.
  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CLEAR) && (clr_addr_r == ADDR_W'(BITMAP_BYTES - 1))) |=>
      (state_r == ST_IDLE))
    else $error("clearing pass did not finish");
`endif

endmodule

[test/tb_two_bit_state_bitmap_engine_unit.sv]
// Testbench for two_bit_state_bitmap_engine_unit: set, find and count beats
// are checked one by one against a bitmap predictor kept in a scoreboard class.
// Depends on tsbe_pkg, tsbe_if and the engine RTL.
module tb_two_bit_state_bitmap_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tsbe_pkg::*;

  localparam int ENTRY_TOTAL  = LANES * BITMAP_BYTES;
  localparam int REGION_RESET = 1024;
  localparam int QUIET_LIMIT  = 20000;
  localparam int LONG_HOLD    = 2000;
  localparam int REPORT_MAX   = 10;
  localparam int PHASES       = 14;

  // Entry state codes
  localparam logic [STATE_W-1:0] SV_FREE    = 2'd0;
  localparam logic [STATE_W-1:0] SV_USED    = 2'd1;
  localparam logic [STATE_W-1:0] SV_INVALID = 2'd2;
  localparam logic [STATE_W-1:0] SV_INODE   = 2'd3;

  // Region sizes for the random phases: mostly small, a few at or past the store size
  localparam int unsigned PHASE_BYTES [PHASES] =
    '{1, 8, 0, 3, 32, 2047, 12, 1024, 2, 64, 5, 1500, 20, 1023};

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
  } answer_t;

  // Bitmap predictor plus the queue of answers still owed by the block.
  class bitmap_scoreboard;
    logic [STATE_W-1:0] entry_state [ENTRY_TOTAL];
    int unsigned        region_bytes;
    answer_t            awaited [$];
    int unsigned        mismatches;

    function new();
      foreach (entry_state[i]) entry_state[i] = SV_FREE;
      region_bytes = REGION_RESET;
      mismatches   = 0;
    endfunction

    function void set_region(input logic [BYTES_W-1:0] nbytes);
      region_bytes = nbytes;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Apply one accepted command to the bitmap and queue the answer it owes.
    function void note_command(input logic [CMD_W-1:0]   cmd,
                               input logic [INDEX_W-1:0] idx,
                               input logic [STATE_W-1:0] val);
      int unsigned limit;
      int unsigned i;
      answer_t     ans;
      limit      = LANES * ((region_bytes > BITMAP_BYTES) ? BITMAP_BYTES : region_bytes);
      ans.status = STAT_OK;
      ans.value  = '0;
      case (cmd)
        CMD_SET: begin
          if (idx < limit) entry_state[idx] = val;
          else ans.status = STAT_RANGE;
        end
        CMD_FIND: begin
          ans.status = STAT_NOT_FOUND;
          for (i = idx; i < limit; i++) begin
            if (entry_state[i] == val) begin
              ans.status = STAT_OK;
              ans.value  = VALUE_W'(i);
              break;
            end
          end
        end
        CMD_COUNT: begin
          for (i = 0; i < limit; i++)
            if (entry_state[i] == val) ans.value = ans.value + VALUE_W'(1);
        end
        default: ;
      endcase
      awaited.push_back(ans);
    endfunction

    function void check_result(input logic [STATUS_W-1:0] status,
                               input logic [VALUE_W-1:0]  value);
      answer_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] result beat with nothing awaited: status %0d value %0d",
                   $time, status, value);
      end else begin
        want = awaited.pop_front();
        if (want.status !== status || want.value !== value) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("[%0t] mismatch: expected status %0d value %0d, got status %0d value %0d",
                     $time, want.status, want.value, status, value);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [BYTES_W-1:0]  cfg_wdata;
  bit                  steady;     // drop all random idling on both sides
  bit                  hold_req;   // ask the receiver for one long hold-off
  bitmap_scoreboard    sb;

  tsbe_in_if  cmd_ch ();
  tsbe_out_if res_ch ();

  two_bit_state_bitmap_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (cmd_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: drive ready at the falling edge. A long hold-off, when asked
  // for, is counted here so the sender keeps offering beats meanwhile.
  initial begin
    int unsigned hold_left;
    int unsigned roll;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (steady || !rst_n) begin
        res_ch.ready <= rst_n;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          res_ch.ready <= 1'b1;
        end else begin
          // mostly brief stalls, now and then a long one
          hold_left = (roll < 96) ? $urandom_range(0, 3) : $urandom_range(20, 150);
          res_ch.ready <= 1'b0;
        end
      end
    end
  end

  // Sample both channels at the rising edge; check results before noting the
  // command of the same edge, which cannot have answered yet.
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.status, res_ch.result_value);
      if (cmd_ch.valid && cmd_ch.ready)
        sb.note_command(cmd_ch.command, cmd_ch.entry_index, cmd_ch.state_value);
    end
  end

  // Watchdog: end the run once nothing has moved on either channel for too long.
  // The longest quiet stretch of a good run is the clearing pass or a long
  // hold-off plus one full scan.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Idle length before a command beat: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Offer one command beat and hold it until accepted. Call at a falling
  // edge; returns at the falling edge after the accept with valid still high,
  // so back-to-back beats never lower and raise valid in one step.
  task automatic send_cmd(input logic [CMD_W-1:0]   cmd,
                          input logic [INDEX_W-1:0] idx,
                          input logic [STATE_W-1:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.command     <= cmd;
    cmd_ch.entry_index <= idx;
    cmd_ch.state_value <= val;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
  endtask

  // Stop offering and wait until every awaited result beat has arrived.
  task automatic wait_drain();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() > 0);
  endtask

  // Write bytes_in_use while the engine is idle.
  task automatic write_region(input logic [BYTES_W-1:0] nbytes);
    wait_drain();
    repeat (4) @(negedge clk);   // let the sequencer fall back to idle
    cfg_we    <= 1'b1;
    cfg_wdata <= nbytes;
    @(posedge clk);
    sb.set_region(nbytes);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random phase at a given region size. Indexes mostly land inside the
  // region so sets take and finds hit; some straddle the region end and some
  // span the whole index field. Drain once halfway through.
  task automatic run_phase(input logic [BYTES_W-1:0] nbytes, input int unsigned items,
                           input bit squeeze);
    int unsigned        span;
    int unsigned        roll;
    int unsigned        n;
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] idx;
    write_region(nbytes);
    span = LANES * ((nbytes > BITMAP_BYTES) ? BITMAP_BYTES : nbytes);
    if (squeeze) hold_req = 1'b1;
    for (n = 0; n < items; n++) begin
      roll = $urandom_range(0, 99);
      cmd  = (roll < 50) ? CMD_SET : (roll < 80) ? CMD_FIND : CMD_COUNT;
      roll = $urandom_range(0, 99);
      if (span == 0 || roll < 15) idx = INDEX_W'($urandom_range(0, ENTRY_TOTAL - 1));
      else if (roll < 22) idx = INDEX_W'(span - 1 + $urandom_range(0, 1));
      else idx = INDEX_W'($urandom_range(0, span - 1));
      send_cmd(cmd, idx, STATE_W'($urandom_range(0, 3)));
      if (n == items / 2) wait_drain();
    end
  endtask

  initial begin
    int unsigned p;
    int unsigned items;
    sb                 = new();
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.command     = CMD_SET;
    cmd_ch.entry_index = '0;
    cmd_ch.state_value = SV_FREE;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset region size. Beats wait out the clearing pass.
    send_cmd(CMD_COUNT, 12'd0,    SV_FREE);     // cleared store: every entry free
    send_cmd(CMD_FIND,  12'd0,    SV_FREE);
    send_cmd(CMD_FIND,  12'd0,    SV_USED);     // nothing used yet: not found
    send_cmd(CMD_SET,   12'd4095, SV_INODE);    // top entry of the store
    send_cmd(CMD_FIND,  12'd0,    SV_INODE);    // full-length scan to the top
    send_cmd(CMD_FIND,  12'd4095, SV_INODE);    // goal on the match itself
    send_cmd(CMD_COUNT, 12'd0,    SV_INODE);
    send_cmd(CMD_SET,   12'd0,    SV_USED);
    send_cmd(CMD_FIND,  12'd1,    SV_USED);     // only match lies before the goal
    send_cmd(CMD_SET,   12'd2048, SV_INVALID);
    send_cmd(CMD_COUNT, 12'hABC,  SV_INVALID);  // count ignores the index

    // Empty region: every set out of range, nothing to find or count.
    write_region(11'd0);
    send_cmd(CMD_SET,   12'd0, SV_INODE);
    send_cmd(CMD_FIND,  12'd0, SV_FREE);
    send_cmd(CMD_COUNT, 12'd0, SV_FREE);

    // One byte in use: entries 0..3 only.
    write_region(11'd1);
    send_cmd(CMD_SET,   12'd3, SV_INVALID);     // last entry inside
    send_cmd(CMD_SET,   12'd4, SV_USED);        // first entry outside
    send_cmd(CMD_FIND,  12'd4, SV_FREE);        // goal outside the region
    send_cmd(CMD_FIND,  12'd0, SV_INVALID);
    send_cmd(CMD_COUNT, 12'd0, SV_INVALID);

    // Region past the store size behaves as the whole store.
    write_region(11'd2047);
    send_cmd(CMD_SET,   12'd4095, SV_FREE);
    send_cmd(CMD_FIND,  12'd4094, SV_FREE);
    send_cmd(CMD_COUNT, 12'd0,    SV_INODE);

    // Random phases; the second one runs under a long receiver hold-off so
    // the engine fills and back-pressures, one every four runs with no idling.
    for (p = 0; p < PHASES; p++) begin
      items  = (PHASE_BYTES[p] > 100) ? 20 : (PHASE_BYTES[p] == 0) ? 15 : 52;
      steady = (p % 4 == 2);
      run_phase(BYTES_W'(PHASE_BYTES[p]), items, p == 1);
    end

    // Drain, then give the engine a little longer to show any stray beat.
    wait_drain();
    steady = 1'b0;
    repeat (40) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
design/tsbe_pkg.sv
design/tsbe_if.sv
design/tsbe_ram.sv
design/tsbe_scan.sv
design/two_bit_state_bitmap_engine_unit.sv
test/tb_two_bit_state_bitmap_engine_unit.sv
